@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl files, included by ufe_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while rst_n is low
`define UFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same cycle implication
`define UFE_ASSERT_IMPLY(label, ante, cons, msg) \
    `UFE_ASSERT(label, (ante) |-> (cons), msg)

// next cycle implication
`define UFE_ASSERT_NEXT(label, ante, cons, msg) \
    `UFE_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/ufe_pkg.sv @@
package ufe_pkg;

    // input opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // sync bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // classified item kinds
    typedef enum logic [1:0] {
        CMD_START,
        CMD_PAYLOAD,
        CMD_ERROR
    } cmd_kind_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic        last;
        logic [7:0]  class_byte;
        logic [7:0]  msg_id;
        logic [15:0] body_len;
        logic [7:0]  data;
    } cmd_t;

    // byte emission phases of the back end
    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_SUM_A,
        PH_SUM_B,
        PH_ERR
    } phase_t;

endpackage

@@ rtl/ufe_front.sv @@
module ufe_front
    import ufe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  class_byte,
    input  logic [7:0]  msg_id,
    input  logic [15:0] body_len,
    input  logic [7:0]  payload_byte,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // classify the transaction against the open frame
    always_comb
    begin
        frame_open_next       = frame_open_reg;
        bytes_left_next       = bytes_left_reg;
        q_cmd.kind            = CMD_ERROR;
        q_cmd.last            = 1'b0;
        q_cmd.class_byte      = class_byte;
        q_cmd.msg_id          = msg_id;
        q_cmd.body_len        = body_len;
        q_cmd.data            = payload_byte;
        if (opcode == OP_START)
        begin
            if (!frame_open_reg)
            begin
                q_cmd.kind = CMD_START;
                q_cmd.last = (body_len == 16'd0);
                if (body_len != 16'd0)
                begin
                    frame_open_next = 1'b1;
                    bytes_left_next = body_len;
                end
            end
        end
        else
        begin
            if (frame_open_reg)
            begin
                q_cmd.kind      = CMD_PAYLOAD;
                q_cmd.last      = (bytes_left_reg == 16'd1);
                bytes_left_next = bytes_left_reg - 16'd1;
                if (bytes_left_reg == 16'd1)
                begin
                    frame_open_next = 1'b0;
                end
            end
        end
    end

    // frame tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
        end
        else if (q_push)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

@@ rtl/ufe_queue.sv @@
module ufe_queue
    import ufe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ rtl/ufe_back.sv @@
module ufe_back
    import ufe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       frame_end,
    output logic       error
);

`include "assert_macros.svh"

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     cur_phase;
    logic       mid_reg;
    logic       done;
    logic       emit;
    logic       out_load;
    logic [7:0] sum_a_reg;
    logic [7:0] sum_a_next;
    logic [7:0] sum_b_reg;
    logic [7:0] sum_b_next;
    logic [7:0] byte_val;
    logic       end_val;
    logic       err_val;
    logic       counted;
    logic       sum_b_emit;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_frame_end_reg;
    logic       out_error_reg;

    assign out_load   = !out_valid_reg || !out_stall;
    assign emit       = head_valid && out_load;
    assign pop        = emit && done;
    assign sum_b_emit = emit && (cur_phase == PH_SUM_B);

    // phase of the head transaction
    always_comb
    begin
        if (mid_reg)
        begin
            cur_phase = phase_reg;
        end
        else
        begin
            case (head_cmd.kind)
                CMD_START:   cur_phase = PH_SYNC1;
                CMD_PAYLOAD: cur_phase = PH_DATA;
                default:     cur_phase = PH_ERR;
            endcase
        end
    end

    // next phase and end of transaction
    always_comb
    begin
        phase_next = cur_phase;
        done       = 1'b0;
        case (cur_phase)
            PH_SYNC1:  phase_next = PH_SYNC2;
            PH_SYNC2:  phase_next = PH_CLASS;
            PH_CLASS:  phase_next = PH_ID;
            PH_ID:     phase_next = PH_LEN_LO;
            PH_LEN_LO: phase_next = PH_LEN_HI;
            PH_LEN_HI, PH_DATA:
            begin
                if (head_cmd.last)
                begin
                    phase_next = PH_SUM_A;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_SUM_A:  phase_next = PH_SUM_B;
            PH_SUM_B:  done = 1'b1;
            default:   done = 1'b1;
        endcase
    end

    // byte value and flags per phase
    always_comb
    begin
        byte_val = 8'd0;
        end_val  = 1'b0;
        err_val  = 1'b0;
        counted  = 1'b0;
        case (cur_phase)
            PH_SYNC1:  byte_val = SYNC_FIRST;
            PH_SYNC2:  byte_val = SYNC_SECOND;
            PH_CLASS:
            begin
                byte_val = head_cmd.class_byte;
                counted  = 1'b1;
            end
            PH_ID:
            begin
                byte_val = head_cmd.msg_id;
                counted  = 1'b1;
            end
            PH_LEN_LO:
            begin
                byte_val = head_cmd.body_len[7:0];
                counted  = 1'b1;
            end
            PH_LEN_HI:
            begin
                byte_val = head_cmd.body_len[15:8];
                counted  = 1'b1;
            end
            PH_DATA:
            begin
                byte_val = head_cmd.data;
                counted  = 1'b1;
            end
            PH_SUM_A:  byte_val = sum_a_reg;
            PH_SUM_B:
            begin
                byte_val = sum_b_reg;
                end_val  = 1'b1;
            end
            default:   err_val = 1'b1;
        endcase
    end

    // fletcher sums, cleared at the first sync byte
    always_comb
    begin
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        if (cur_phase == PH_SYNC1)
        begin
            sum_a_next = 8'd0;
            sum_b_next = 8'd0;
        end
        else if (counted)
        begin
            sum_a_next = sum_a_reg + byte_val;
            sum_b_next = sum_b_reg + sum_a_next;
        end
    end

    // sequencer and sum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            mid_reg   <= 1'b0;
            sum_a_reg <= 8'd0;
            sum_b_reg <= 8'd0;
        end
        else if (emit)
        begin
            phase_reg <= phase_next;
            mid_reg   <= !done;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= emit;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg      <= byte_val;
            out_frame_end_reg <= end_val;
            out_error_reg     <= err_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = out_frame_end_reg;
    assign error     = out_error_reg;

    `UFE_ASSERT_IMPLY(a_mid_has_head, mid_reg, head_valid, "mid transaction without queue head")
    `UFE_ASSERT_IMPLY(a_pop_on_emit, pop, emit && head_valid, "pop without an emitted byte")
    `UFE_ASSERT_NEXT(a_sum_b_ends, sum_b_emit, out_valid_reg && out_frame_end_reg, "no frame end")
    `UFE_ASSERT_IMPLY(a_err_clean, out_valid_reg && out_error_reg, (out_byte_reg == 8'd0) && !out_frame_end_reg, "error result carries data")

endmodule

@@ rtl/ubx_frame_encoder_core.sv @@
// Frame encoder: a start transaction (class, id, 16-bit length) produces the sync bytes B5 62,
// class, id and length low/high, then each payload transaction passes its byte through, and
// the two 8-bit Fletcher sums over class..payload follow the last counted byte (or the header
// when the length is zero), the second one flagged by frame_end. Out-of-sequence transactions
// give one result with error set and out_byte zero. Inputs are classified on acceptance and
// queued (QUEUE_DEPTH entries, at least 2); the byte serializer behind the queue writes one
// output byte per cycle unless out_stall holds it: a payload transaction yields 1 byte, 3 when
// it closes the frame, and a start transaction 6 bytes, 8 for an empty frame. While a header
// or checksum burst drains, up to QUEUE_DEPTH - 1 further transactions wait in the queue;
// in_stall rises only when the queue is full.
module ubx_frame_encoder_core
    import ufe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  class_byte,
    input  logic [7:0]  msg_id,
    input  logic [15:0] body_len,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        error
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic head_valid;
    cmd_t head_cmd;

    // input classification
    ufe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .class_byte   (class_byte),
        .msg_id       (msg_id),
        .body_len     (body_len),
        .payload_byte (payload_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    // command queue between front and back
    ufe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // byte serializer and checksum
    ufe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .frame_end  (frame_end),
        .error      (error)
    );

endmodule
